// ----- design/bzt_pkg.sv -----
package bzt_pkg;

  localparam int unsigned BaseClkHz   = 1000000;
  localparam int unsigned FullScale   = 100;
  localparam int unsigned ResetPeriod = 1000;

  localparam int unsigned VolW    = 7;
  localparam int unsigned FreqW   = 16;
  localparam int unsigned DurW    = 16;
  localparam int unsigned PeriodW = 20;
  localparam int unsigned LevelW  = 19;

  // dividend wide enough for volume times half period
  localparam int unsigned DivW  = VolW + LevelW;
  localparam int unsigned DsrW  = 16;
  localparam int unsigned DivCntW = $clog2(DivW);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_LEVEL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [FreqW-1:0] tone_freq_hz;
    logic [DurW-1:0]  duration_ms;
  } in_t;

  typedef struct packed {
    logic [PeriodW-1:0] period_top;
    logic [LevelW-1:0]  duty_level;
    logic               sounding;
  } out_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/buzzer_tone_timer.sv -----
// buzzer tone timer: keeps the wrap value and compare level of a buzzer pwm
// running from a 1 mhz base clock.
// input channel (in_valid_i / in_stall_o / in_data_i): a millisecond tick,
// a start command (frequency, duration) or a stop command. every accepted
// item gives exactly one result on the output channel (out_valid_o /
// out_stall_i / out_data_o) with the pwm state after that item.
// config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): volume in
// percent, always ready, values above 100 are stored as 100.
// a tick, a stop or an ignored command has its result loaded into the output
// register in the cycle of the transfer.
// a start with nonzero frequency is launched into two passes through one shared
// restoring divider (1000000 / freq, then volume times half period / 100), then
// its result is written back to the output register. input is stalled meanwhile.
// the output register holds one result; while it is full and the receiver
// stalls, the input is stalled as well and nothing is lost.
// reset: volume 100, period 1000, level 0, silent, output empty.
module buzzer_tone_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bzt_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bzt_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bzt_pkg::VolW-1:0]      cfg_data_i
);

  bzt_pkg::state_e                  state_q, state_d;
  logic [bzt_pkg::VolW-1:0]         vol_q, vol_d;
  logic                             active_q, active_d;
  logic [bzt_pkg::DurW-1:0]         remain_q, remain_d;
  logic [bzt_pkg::PeriodW-1:0]      period_q, period_d;
  logic [bzt_pkg::LevelW-1:0]       level_q, level_d;
  logic [bzt_pkg::DurW-1:0]         dur_q, dur_d;
  logic                             out_valid_q, out_valid_d;
  bzt_pkg::out_t                    out_q, out_d;

  bzt_pkg::div_req_t                div_req;
  bzt_pkg::div_rsp_t                div_rsp;

  logic                             out_free;
  logic                             in_xfer;
  logic [bzt_pkg::DurW-1:0]         remain_dec;

  bzt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != bzt_pkg::ST_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign remain_dec = remain_q - 1'b1;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    vol_d       = vol_q;
    active_d    = active_q;
    remain_d    = remain_q;
    period_d    = period_q;
    level_d     = level_q;
    dur_d       = dur_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    div_req.start    = 1'b0;
    div_req.dividend = bzt_pkg::DivW'(bzt_pkg::BaseClkHz);
    div_req.divisor  = in_data_i.tone_freq_hz;

    if (cfg_valid_i) begin
      vol_d = (cfg_data_i > bzt_pkg::VolW'(bzt_pkg::FullScale))
              ? bzt_pkg::VolW'(bzt_pkg::FullScale) : cfg_data_i;
    end

    case (state_q)
      bzt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (bzt_pkg::mode_e'(in_data_i.mode))
            bzt_pkg::MODE_TICK: begin
              if (active_q && remain_q != '0) begin
                remain_d = remain_dec;
                if (remain_dec == '0) begin
                  level_d  = '0;
                  active_d = 1'b0;
                end
              end
            end
            bzt_pkg::MODE_START: begin
              if (in_data_i.tone_freq_hz != '0) begin
                div_req.start = 1'b1;
                dur_d         = in_data_i.duration_ms;
                state_d       = bzt_pkg::ST_PERIOD;
              end
            end
            bzt_pkg::MODE_STOP: begin
              level_d  = '0;
              active_d = 1'b0;
            end
            default: ;
          endcase
          if (state_d == bzt_pkg::ST_IDLE) begin
            out_valid_d      = 1'b1;
            out_d.period_top = period_d;
            out_d.duty_level = level_d;
            out_d.sounding   = active_d;
          end
        end
      end
      bzt_pkg::ST_PERIOD: begin
        if (div_rsp.done) begin
          period_d         = div_rsp.quotient[bzt_pkg::PeriodW-1:0];
          // level = volume * (period / 2) / 100
          div_req.start    = 1'b1;
          div_req.dividend = bzt_pkg::DivW'(vol_q)
                             * bzt_pkg::DivW'(div_rsp.quotient[bzt_pkg::PeriodW-1:1]);
          div_req.divisor  = bzt_pkg::DsrW'(bzt_pkg::FullScale);
          state_d          = bzt_pkg::ST_LEVEL;
        end
      end
      bzt_pkg::ST_LEVEL: begin
        if (div_rsp.done) begin
          level_d  = div_rsp.quotient[bzt_pkg::LevelW-1:0];
          active_d = 1'b1;
          remain_d = dur_q;
          state_d  = bzt_pkg::ST_EMIT;
        end
      end
      bzt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.period_top = period_q;
          out_d.duty_level = level_q;
          out_d.sounding   = active_q;
          state_d          = bzt_pkg::ST_IDLE;
        end
      end
      default: state_d = bzt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bzt_pkg::ST_IDLE;
      vol_q       <= bzt_pkg::VolW'(bzt_pkg::FullScale);
      active_q    <= 1'b0;
      remain_q    <= '0;
      period_q    <= bzt_pkg::PeriodW'(bzt_pkg::ResetPeriod);
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vol_q       <= vol_d;
      active_q    <= active_d;
      remain_q    <= remain_d;
      period_q    <= period_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dur_q <= dur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/bzt_div.sv -----
module bzt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bzt_pkg::div_req_t  req_i,
  output bzt_pkg::div_rsp_t  rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [bzt_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic [bzt_pkg::DivW-1:0]       quo_q, quo_d;
  logic [bzt_pkg::DsrW-1:0]       rem_q, rem_d;
  logic [bzt_pkg::DsrW-1:0]       dsr_q, dsr_d;
  logic [bzt_pkg::DsrW:0]         trial;
  logic [bzt_pkg::DsrW:0]         diff;
  logic                           fits;

  // one restoring step per cycle, msb first
  assign trial = {rem_q, quo_q[bzt_pkg::DivW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = bzt_pkg::DivCntW'(bzt_pkg::DivW - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[bzt_pkg::DivW-2:0], fits};
      rem_d = fits ? diff[bzt_pkg::DsrW-1:0] : trial[bzt_pkg::DsrW-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- bench/buzzer_tone_timer_chk.sv -----
module buzzer_tone_timer_chk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  bzt_pkg::in_t                      in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  bzt_pkg::out_t                     out_data_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [bzt_pkg::VolW-1:0]          cfg_data_i,
  output int                                err_count_o,
  output int                                pending_o
);

  localparam int unsigned ShownMismatches = 10;

  logic [bzt_pkg::VolW-1:0]    vol;
  logic                        tone_on;
  logic [bzt_pkg::DurW-1:0]    ms_left;
  logic [bzt_pkg::PeriodW-1:0] wrap_val;
  logic [bzt_pkg::LevelW-1:0]  cmp_level;

  bzt_pkg::out_t pwm_state_q[$];

  // advances the predicted pwm state by one input item
  function automatic bzt_pkg::out_t next_pwm_state(bzt_pkg::in_t it);
    int unsigned   wrap_full;
    int unsigned   half_lvl;
    bzt_pkg::out_t res;
    case (bzt_pkg::mode_e'(it.mode))
      bzt_pkg::MODE_TICK: begin
        if (tone_on && ms_left != '0) begin
          ms_left = ms_left - 1'b1;
          if (ms_left == '0) begin
            cmp_level = '0;
            tone_on   = 1'b0;
          end
        end
      end
      bzt_pkg::MODE_START: begin
        if (it.tone_freq_hz != '0) begin
          wrap_full = bzt_pkg::BaseClkHz / it.tone_freq_hz;
          half_lvl  = (vol * (wrap_full / 2)) / bzt_pkg::FullScale;
          wrap_val  = wrap_full[bzt_pkg::PeriodW-1:0];
          cmp_level = half_lvl[bzt_pkg::LevelW-1:0];
          tone_on   = 1'b1;
          ms_left   = it.duration_ms;
        end
      end
      bzt_pkg::MODE_STOP: begin
        cmp_level = '0;
        tone_on   = 1'b0;
      end
      default: ;
    endcase
    res.period_top = wrap_val;
    res.duty_level = cmp_level;
    res.sounding   = tone_on;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bzt_pkg::out_t want;
    if (!rst_ni) begin
      vol         = bzt_pkg::VolW'(bzt_pkg::FullScale);
      tone_on     = 1'b0;
      ms_left     = '0;
      wrap_val    = bzt_pkg::PeriodW'(bzt_pkg::ResetPeriod);
      cmp_level   = '0;
      pwm_state_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        vol = (cfg_data_i > bzt_pkg::FullScale)
              ? bzt_pkg::VolW'(bzt_pkg::FullScale) : cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        pwm_state_q.push_back(next_pwm_state(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (pwm_state_q.size() == 0) begin
          if (err_count_o < ShownMismatches) begin
            $display("unexpected transfer: period %0d level %0d sounding %0b",
                     out_data_i.period_top, out_data_i.duty_level, out_data_i.sounding);
          end
          err_count_o++;
        end else begin
          want = pwm_state_q.pop_front();
          if (want.period_top !== out_data_i.period_top ||
              want.duty_level !== out_data_i.duty_level ||
              want.sounding   !== out_data_i.sounding) begin
            if (err_count_o < ShownMismatches) begin
              $display("mismatch: expected period %0d level %0d sounding %0b, got %0d %0d %0b",
                       want.period_top, want.duty_level, want.sounding,
                       out_data_i.period_top, out_data_i.duty_level, out_data_i.sounding);
            end
            err_count_o++;
          end
        end
      end
      pending_o = pwm_state_q.size();
    end
  end

endmodule

// ----- bench/buzzer_tone_timer_tb.sv -----
module buzzer_tone_timer_tb;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int         CycleLimit = 600000;
  localparam int         PhaseItems = 200;
  localparam int         HoldCycles = 400;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  bzt_pkg::in_t             in_data_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  bzt_pkg::out_t            out_data_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [bzt_pkg::VolW-1:0] cfg_data_i = '0;

  int err_count;
  int pending;
  int cycles = 0;
  int tx_idle_pct = 29;
  int rx_idle_pct = 60;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int items_sent = 0;

  buzzer_tone_timer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  buzzer_tone_timer_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic bzt_pkg::in_t mk_item(logic [1:0] m, logic [bzt_pkg::FreqW-1:0] f,
                                           logic [bzt_pkg::DurW-1:0] d);
    bzt_pkg::in_t it;
    it.mode         = m;
    it.tone_freq_hz = f;
    it.duration_ms  = d;
    return it;
  endfunction

  // random contents in the fields that the mode ignores
  function automatic bzt_pkg::in_t rnd_item(logic [1:0] m);
    return mk_item(m, bzt_pkg::FreqW'($urandom), bzt_pkg::DurW'($urandom));
  endfunction

  task automatic send_item(bzt_pkg::in_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // wait until every expected result has come back, then wait out the given tail
  task automatic settle(int tail);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_volume(logic [bzt_pkg::VolW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [bzt_pkg::FreqW-1:0] pick_freq();
    case ($urandom_range(3))
      0:       return bzt_pkg::FreqW'($urandom_range(1, 20));
      1:       return bzt_pkg::FreqW'($urandom_range(200, 5000));
      2:       return bzt_pkg::FreqW'(16'hFFFF - $urandom_range(0, 15));
      default: return bzt_pkg::FreqW'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [bzt_pkg::DurW-1:0] pick_dur();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return bzt_pkg::DurW'($urandom_range(0, 65535));
    return bzt_pkg::DurW'($urandom_range(1, 6));
  endfunction

  task automatic run_phase(int n_items);
    int                        stop_at;
    int                        r;
    int                        n_ticks;
    logic [bzt_pkg::DurW-1:0]  d;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) begin
        // a tone: start, ticks around its length, sometimes cut short by a stop
        d = pick_dur();
        send_item(mk_item(bzt_pkg::MODE_START, pick_freq(), d));
        if (d != '0 && d <= 8) n_ticks = $urandom_range(d - 1, d + 2);
        else n_ticks = $urandom_range(0, 4);
        repeat (n_ticks) send_item(rnd_item(bzt_pkg::MODE_TICK));
        if ($urandom_range(9) < 3) send_item(rnd_item(bzt_pkg::MODE_STOP));
      end else if (r < 75) begin
        send_item(rnd_item(bzt_pkg::MODE_TICK));
      end else if (r < 85) begin
        send_item(rnd_item(bzt_pkg::MODE_STOP));
      end else if (r < 92) begin
        send_item(mk_item(bzt_pkg::MODE_START, '0, bzt_pkg::DurW'($urandom)));
      end else begin
        send_item(rnd_item(ModeUnused));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset volume
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'hFFFF, 16'hFFFF));
    send_item(mk_item(bzt_pkg::MODE_STOP, 16'h1234, 16'h00FF));
    send_item(mk_item(bzt_pkg::MODE_START, 16'h0000, 16'd5));
    send_item(mk_item(ModeUnused, 16'hFFFF, 16'hFFFF));
    send_item(mk_item(bzt_pkg::MODE_START, 16'd1, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'd0, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_STOP, 16'hFFFF, 16'hFFFF));
    send_item(mk_item(bzt_pkg::MODE_START, 16'hFFFF, 16'd2));
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'd0, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'd0, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'd0, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_START, 16'd1000, 16'hFFFF));
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'd0, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_START, 16'd3, 16'd1));
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'd0, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_START, 16'd440, 16'd3));
    send_item(mk_item(bzt_pkg::MODE_STOP, 16'd0, 16'd0));
    // remaining count survives the stop but a silent tone does not count down
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'd0, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_START, 16'd2, 16'd0));
    send_item(mk_item(ModeUnused, 16'd0, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_START, 16'd0, 16'd7));
    send_item(mk_item(bzt_pkg::MODE_STOP, 16'd0, 16'd0));
    settle(8);

    write_volume(7'd0);
    send_item(mk_item(bzt_pkg::MODE_START, 16'd1000, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_STOP, 16'd0, 16'd0));
    settle(8);

    // above full scale saturates
    write_volume(7'h7F);
    send_item(mk_item(bzt_pkg::MODE_START, 16'd1, 16'd1));
    send_item(mk_item(bzt_pkg::MODE_TICK, 16'd0, 16'd0));
    settle(8);

    write_volume(7'd1);
    send_item(mk_item(bzt_pkg::MODE_START, 16'd1, 16'd0));
    send_item(mk_item(bzt_pkg::MODE_STOP, 16'd0, 16'd0));
    settle(8);

    write_volume(bzt_pkg::VolW'($urandom_range(0, 127)));
    run_phase(PhaseItems);
    settle(8);

    tx_idle_pct = 60;
    rx_idle_pct = 29;
    write_volume(7'd50);
    run_phase(PhaseItems);
    settle(8);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_volume(bzt_pkg::VolW'($urandom_range(0, 127)));
    hold_req = 1'b1;
    run_phase(PhaseItems);
    settle(60);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bzt_pkg.sv
design/bzt_div.sv
design/buzzer_tone_timer.sv
bench/buzzer_tone_timer_chk.sv
bench/buzzer_tone_timer_tb.sv
